FILE: src/dgsfd_pkg.sv
// Shared types and constants for the dial gauge serial frame decoder.
// Used by the front decoder, the report serializer and the top level.
package dgsfd_pkg;

  localparam int unsigned BYTES_W   = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_INTERVAL = 1'b0,
    CFG_CUTOFF_TICKS    = 1'b1
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] SAMPLE_INTERVAL_RST = 16'd348;
  localparam logic [CFG_W-1:0] CUTOFF_TICKS_RST    = 16'd8832;

  localparam logic [7:0] CH_MEAS    = 8'h4D;  // 'M'
  localparam logic [7:0] CH_ERR     = 8'h45;  // 'E'
  localparam logic [7:0] CH_FIVE    = 8'h35;  // '5'
  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Summary of one finished frame, passed from the decoder to the serializer.
  typedef struct packed {
    logic               measurement_ok;
    logic [2:0]         bits_in_byte;
    logic [BYTES_W-1:0] bytes_received;
  } frame_info_t;

endpackage

FILE: src/dgsfd_front.sv
// Front decoder: edge detection, bit sampling with majority vote, byte
// assembly and frame cutoff. Depends on dgsfd_pkg.
module dgsfd_front #(
  parameter int unsigned FRAME_LENGTH = 3,
  parameter int unsigned MAX_BYTES    = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      clock_level_i,
  input  logic                      data_level_i,
  input  logic [15:0]               sample_interval_i,
  input  logic [15:0]               cutoff_ticks_i,
  output logic                      evt_valid_o,
  output dgsfd_pkg::frame_info_t    evt_info_o,
  output logic [FRAME_LENGTH*8-1:0] evt_bytes_o
);
  import dgsfd_pkg::*;

  logic               clock_prev_q, clock_prev_d;
  logic               in_bit_q, in_bit_d;
  logic [15:0]        sample_timer_q, sample_timer_d;
  logic [15:0]        ones_q, ones_d;
  logic [15:0]        samples_q, samples_d;
  logic [7:0]         shift_q, shift_d;
  logic [2:0]         bits_q, bits_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic               await_q, await_d;
  logic [15:0]        idle_q, idle_d;
  logic [7:0]         frame_q [FRAME_LENGTH];

  logic               fall, rise, bit_val, byte_done, frame_end;
  logic [7:0]         new_byte;
  logic [15:0]        timer_inc, idle_inc;

  assign fall      = clock_prev_q & ~clock_level_i;
  assign rise      = ~clock_prev_q & clock_level_i;
  assign bit_val   = ones_q > (samples_q >> 1);
  assign new_byte  = {bit_val, shift_q[7:1]};
  assign timer_inc = sample_timer_q + 16'd1;
  assign idle_inc  = idle_q + 16'd1;

  always_comb begin
    clock_prev_d   = clock_level_i;
    in_bit_d       = in_bit_q;
    sample_timer_d = sample_timer_q;
    ones_d         = ones_q;
    samples_d      = samples_q;
    shift_d        = shift_q;
    bits_d         = bits_q;
    bytes_d        = bytes_q;
    await_d        = await_q;
    idle_d         = idle_q;
    byte_done      = 1'b0;
    frame_end      = 1'b0;
    if (fall) begin
      in_bit_d       = 1'b1;
      await_d        = 1'b0;
      idle_d         = '0;
      sample_timer_d = '0;
      ones_d         = {15'd0, data_level_i};
      samples_d      = 16'd1;
    end else if (rise) begin
      if (in_bit_q) begin
        if (bits_q == 3'd7) begin
          byte_done = 1'b1;
          shift_d   = '0;
          bits_d    = '0;
          if (bytes_q < BYTES_W'(MAX_BYTES)) begin
            bytes_d = bytes_q + BYTES_W'(1);
          end
        end else begin
          shift_d = new_byte;
          bits_d  = bits_q + 3'd1;
        end
      end
      in_bit_d = 1'b0;
      await_d  = 1'b1;
      idle_d   = '0;
    end else if (!clock_level_i) begin
      if (in_bit_q) begin
        if (timer_inc >= sample_interval_i) begin
          sample_timer_d = '0;
          if (samples_q != 16'hFFFF) samples_d = samples_q + 16'd1;
          if (data_level_i && ones_q != 16'hFFFF) ones_d = ones_q + 16'd1;
        end else begin
          sample_timer_d = timer_inc;
        end
      end
    end else if (await_q) begin
      if (idle_inc >= cutoff_ticks_i) begin
        frame_end = 1'b1;
        shift_d   = '0;
        bits_d    = '0;
        bytes_d   = '0;
        await_d   = 1'b0;
        idle_d    = '0;
      end else begin
        idle_d = idle_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_prev_q   <= 1'b1;
      in_bit_q       <= 1'b0;
      sample_timer_q <= '0;
      ones_q         <= '0;
      samples_q      <= '0;
      shift_q        <= '0;
      bits_q         <= '0;
      bytes_q        <= '0;
      await_q        <= 1'b0;
      idle_q         <= '0;
    end else if (accept_i) begin
      clock_prev_q   <= clock_prev_d;
      in_bit_q       <= in_bit_d;
      sample_timer_q <= sample_timer_d;
      ones_q         <= ones_d;
      samples_q      <= samples_d;
      shift_q        <= shift_d;
      bits_q         <= bits_d;
      bytes_q        <= bytes_d;
      await_q        <= await_d;
      idle_q         <= idle_d;
    end
  end

  // Only the first FRAME_LENGTH bytes of a frame are kept.
  for (genvar i = 0; i < FRAME_LENGTH; i++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (accept_i && byte_done && bytes_q == BYTES_W'(i)) begin
        frame_q[i] <= new_byte;
      end
    end
    assign evt_bytes_o[i*8 +: 8] = frame_q[i];
  end

  assign evt_valid_o                = accept_i & frame_end;
  assign evt_info_o.measurement_ok  = (bits_q == 3'd0) && (bytes_q == BYTES_W'(FRAME_LENGTH));
  assign evt_info_o.bits_in_byte    = bits_q;
  assign evt_info_o.bytes_received  = bytes_q;

endmodule

FILE: src/dgsfd_queue.sv
// Short FIFO of finished frame reports between the decoder and the
// serializer. No package dependencies.
module dgsfd_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) count_d = count_q + CNT_W'(1);
    else if (do_pop && !do_push) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: src/dgsfd_back.sv
// Report serializer: turns one queued frame report into its ASCII packet,
// one character per transaction, through an output register. Depends on dgsfd_pkg.
module dgsfd_back #(
  parameter int unsigned FRAME_LENGTH = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  dgsfd_pkg::frame_info_t    head_info_i,
  input  logic [FRAME_LENGTH*8-1:0] head_bytes_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                character_o,
  output logic                      measurement_ok_o,
  output logic                      last_o
);
  import dgsfd_pkg::*;

  localparam int unsigned MEAS_LEN = 2 * FRAME_LENGTH + 2;
  // The index must also reach the fifth character of an error packet.
  localparam int unsigned IDX_W    = $clog2((MEAS_LEN > 5) ? MEAS_LEN : 5);
  localparam int unsigned NIB_W    = (2 * FRAME_LENGTH > 1) ? $clog2(2 * FRAME_LENGTH) : 1;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] nib_sel;
  logic [3:0]       nib_a [2*FRAME_LENGTH];
  logic             load, is_last;
  logic [7:0]       char_sel;
  logic             out_valid_q;
  logic [7:0]       char_q;
  logic             ok_q, last_q;

  // Nibble k is the low nibble of byte k/2 for even k and its high nibble otherwise.
  for (genvar k = 0; k < 2 * FRAME_LENGTH; k++) begin : g_nib
    assign nib_a[k] = head_bytes_i[k*4 +: 4];
  end

  assign nib_sel = idx_q - IDX_W'(1);
  assign load    = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign is_last = head_info_i.measurement_ok ? (idx_q == IDX_W'(MEAS_LEN - 1))
                                              : (idx_q == IDX_W'(4));

  always_comb begin
    if (head_info_i.measurement_ok) begin
      if (idx_q == '0) char_sel = CH_MEAS;
      else if (is_last) char_sel = CH_NEWLINE;
      else char_sel = CH_UPPER_A + {4'd0, nib_a[nib_sel[NIB_W-1:0]]};
    end else begin
      case (idx_q)
        IDX_W'(0): char_sel = CH_ERR;
        IDX_W'(1): char_sel = CH_FIVE;
        IDX_W'(2): char_sel = CH_UPPER_A + {5'd0, head_info_i.bits_in_byte};
        IDX_W'(3): char_sel = CH_LOWER_A + {3'd0, head_info_i.bytes_received};
        default:   char_sel = CH_NEWLINE;
      endcase
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (load) idx_d = is_last ? '0 : idx_q + IDX_W'(1);
  end

  assign pop_o = load & is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (!out_valid_q || !out_stall_i) out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_sel;
      ok_q   <= head_info_i.measurement_ok;
      last_q <= is_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign character_o      = char_q;
  assign measurement_ok_o = ok_q;
  assign last_o           = last_q;

endmodule

FILE: src/dial_gauge_serial_frame_decoder_core.sv
// Decodes the clock/data lines of a 24-bit caliper-style gauge, one tick per
// accepted transaction, and reports each frame as an ASCII packet: 'M' plus
// 2*FRAME_LENGTH nibble letters and a newline, or a five-character error packet.
// The decoder takes one tick every cycle; it stalls only while the two-entry
// report queue is full. The serializer sends one character per cycle while
// out_stall_i is low; a report is 2*FRAME_LENGTH+2 characters (measurement) or
// 5 characters (error). Registers: index 0 sample_interval, index 1 cutoff_ticks.
// Depends on dgsfd_pkg, dgsfd_front, dgsfd_queue and dgsfd_back.
module dial_gauge_serial_frame_decoder_core #(
  parameter int unsigned FRAME_LENGTH = 3,
  parameter int unsigned MAX_BYTES    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                clock_level_i,
  input  logic                                data_level_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          character_o,
  output logic                                measurement_ok_o,
  output logic                                last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dgsfd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dgsfd_pkg::CFG_W-1:0]         cfg_data_i
);
  import dgsfd_pkg::*;

  localparam int unsigned INFO_W  = $bits(frame_info_t);
  localparam int unsigned ENTRY_W = INFO_W + FRAME_LENGTH * 8;

  logic [CFG_W-1:0]          sample_interval_q, cutoff_ticks_q;
  logic                      accept, evt_valid, q_full, q_empty, pop;
  frame_info_t               evt_info, head_info;
  logic [FRAME_LENGTH*8-1:0] evt_bytes, head_bytes;
  logic [ENTRY_W-1:0]        head_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_interval_q <= SAMPLE_INTERVAL_RST;
      cutoff_ticks_q    <= CUTOFF_TICKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SAMPLE_INTERVAL: sample_interval_q <= cfg_data_i;
        CFG_CUTOFF_TICKS:    cutoff_ticks_q    <= cfg_data_i;
        default:             ;
      endcase
    end
  end

  // Any tick may end a frame, so ticks are held off while no queue slot is free.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i & ~in_stall_o;

  dgsfd_front #(
    .FRAME_LENGTH (FRAME_LENGTH),
    .MAX_BYTES    (MAX_BYTES)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .clock_level_i     (clock_level_i),
    .data_level_i      (data_level_i),
    .sample_interval_i (sample_interval_q),
    .cutoff_ticks_i    (cutoff_ticks_q),
    .evt_valid_o       (evt_valid),
    .evt_info_o        (evt_info),
    .evt_bytes_o       (evt_bytes)
  );

  dgsfd_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (evt_valid),
    .push_data_i ({evt_info, evt_bytes}),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head_entry)
  );

  assign head_info  = frame_info_t'(head_entry[ENTRY_W-1 -: INFO_W]);
  assign head_bytes = head_entry[FRAME_LENGTH*8-1:0];

  dgsfd_back #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (~q_empty),
    .head_info_i      (head_info),
    .head_bytes_i     (head_bytes),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .character_o      (character_o),
    .measurement_ok_o (measurement_ok_o),
    .last_o           (last_o)
  );

endmodule

FILE: tb/frame_decoder_checker.sv
// Scoreboard for the dial gauge serial frame decoder: watches the tick, report and
// register channels, predicts every report character and compares it on arrival.
// Depends on dgsfd_pkg for register indexes, character codes and widths.
module frame_decoder_checker
  import dgsfd_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = 3,
  parameter int unsigned MAX_BYTES    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 clock_level_i,
  input  logic                 data_level_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [7:0]           character_i,
  input  logic                 measurement_ok_i,
  input  logic                 last_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   mismatches_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [7:0] character;
    logic       measurement_ok;
    logic       last;
  } report_char_t;

  report_char_t expected_chars[$];
  report_char_t want;
  int           mismatches = 0;

  logic [CFG_W-1:0]   cfg_interval;
  logic [CFG_W-1:0]   cfg_cutoff;
  logic               gauge_clk_q;
  logic               bit_open;
  logic               cutoff_armed;
  logic [15:0]        sample_wait;
  logic [15:0]        ones_count;
  logic [15:0]        sample_count;
  logic [15:0]        idle_count;
  logic [7:0]         shift_q;
  logic [2:0]         bit_count;
  logic [7:0]         frame_store [FRAME_LENGTH];
  logic [BYTES_W-1:0] byte_count;

  assign mismatches_o = mismatches;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_char(input logic [7:0] ch, input logic ok, input logic lst);
    expected_chars.push_back({ch, ok, lst});
  endtask

  // A frame that ends with exactly FRAME_LENGTH whole bytes is a measurement,
  // anything else is reported as an error with its bit and byte counts.
  task automatic close_frame();
    if (bit_count == 3'd0 && byte_count == FRAME_LENGTH) begin
      push_char(CH_MEAS, 1'b1, 1'b0);
      for (int unsigned i = 0; i < FRAME_LENGTH; i++) begin
        push_char(CH_UPPER_A + {4'd0, frame_store[i][3:0]}, 1'b1, 1'b0);
        push_char(CH_UPPER_A + {4'd0, frame_store[i][7:4]}, 1'b1, 1'b0);
      end
      push_char(CH_NEWLINE, 1'b1, 1'b1);
    end else begin
      push_char(CH_ERR, 1'b0, 1'b0);
      push_char(CH_FIVE, 1'b0, 1'b0);
      push_char(CH_UPPER_A + {5'd0, bit_count}, 1'b0, 1'b0);
      push_char(CH_LOWER_A + {3'd0, byte_count}, 1'b0, 1'b0);
      push_char(CH_NEWLINE, 1'b0, 1'b1);
    end
    shift_q      = '0;
    bit_count    = '0;
    byte_count   = '0;
    cutoff_armed = 1'b0;
    idle_count   = '0;
  endtask

  task automatic decode_tick(input logic lvl, input logic data);
    logic vote;
    if (gauge_clk_q && !lvl) begin
      bit_open     = 1'b1;
      cutoff_armed = 1'b0;
      idle_count   = '0;
      sample_wait  = '0;
      ones_count   = {15'd0, data};
      sample_count = 16'd1;
    end else if (!gauge_clk_q && lvl) begin
      if (bit_open) begin
        vote    = ones_count > (sample_count >> 1);
        shift_q = {vote, shift_q[7:1]};
        if (bit_count == 3'd7) begin
          if (byte_count < FRAME_LENGTH) frame_store[byte_count] = shift_q;
          if (byte_count < MAX_BYTES) byte_count++;
          shift_q   = '0;
          bit_count = '0;
        end else begin
          bit_count++;
        end
      end
      bit_open     = 1'b0;
      cutoff_armed = 1'b1;
      idle_count   = '0;
    end else if (!lvl) begin
      if (bit_open) begin
        sample_wait++;
        // An interval of zero compares true on every tick, the same as one.
        if (sample_wait >= cfg_interval) begin
          sample_wait = '0;
          if (sample_count != 16'hFFFF) sample_count++;
          if (data && ones_count != 16'hFFFF) ones_count++;
        end
      end
    end else if (cutoff_armed) begin
      idle_count++;
      if (idle_count >= cfg_cutoff) close_frame();
    end
    gauge_clk_q = lvl;
  endtask

  // Results are compared before the tick of the same edge is decoded, since a
  // tick can never produce a character on the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_chars.delete();
      cfg_interval = SAMPLE_INTERVAL_RST;
      cfg_cutoff   = CUTOFF_TICKS_RST;
      gauge_clk_q  = 1'b1;
      bit_open     = 1'b0;
      cutoff_armed = 1'b0;
      sample_wait  = '0;
      ones_count   = '0;
      sample_count = '0;
      idle_count   = '0;
      shift_q      = '0;
      bit_count    = '0;
      byte_count   = '0;
      foreach (frame_store[j]) frame_store[j] = '0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          flag_mismatch($sformatf("character %02h ok %0b last %0b with nothing expected",
                                  character_i, measurement_ok_i, last_i));
        end else begin
          want = expected_chars.pop_front();
          if (want !== {character_i, measurement_ok_i, last_i}) begin
            flag_mismatch($sformatf("got char %02h ok %0b last %0b, want %02h ok %0b last %0b",
                                    character_i, measurement_ok_i, last_i,
                                    want.character, want.measurement_ok, want.last));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_SAMPLE_INTERVAL: cfg_interval = cfg_data_i;
          CFG_CUTOFF_TICKS:    cfg_cutoff   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) decode_tick(clock_level_i, data_level_i);
      pending_o <= expected_chars.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the frame decoder regression: drives gauge ticks and register writes,
// applies back-pressure on the report channel and gives the verdict.
// Depends on dgsfd_pkg, dial_gauge_serial_frame_decoder_core and frame_decoder_checker.
module testbench;
  import dgsfd_pkg::*;

  localparam int unsigned FRAME_LENGTH  = 3;
  localparam int unsigned MAX_BYTES     = 16;
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 16;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             clock_level_i = 1'b1;
  logic             data_level_i  = 1'b0;
  logic             out_stall_i   = 1'b0;
  logic             cfg_valid_i   = 1'b0;
  cfg_reg_e         cfg_index_i   = CFG_SAMPLE_INTERVAL;
  logic [CFG_W-1:0] cfg_data_i    = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [7:0]       character_o;
  logic             measurement_ok_o;
  logic             last_o;
  logic             cfg_ready_o;

  int          mismatches;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned ticks_sent  = 0;
  int unsigned hold_asks   = 0;
  int unsigned hold_taken  = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  int unsigned cur_cutoff  = CUTOFF_TICKS_RST;
  logic        calm;

  dial_gauge_serial_frame_decoder_core #(
    .FRAME_LENGTH(FRAME_LENGTH),
    .MAX_BYTES   (MAX_BYTES)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .clock_level_i   (clock_level_i),
    .data_level_i    (data_level_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .character_o     (character_o),
    .measurement_ok_o(measurement_ok_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  frame_decoder_checker #(
    .FRAME_LENGTH(FRAME_LENGTH),
    .MAX_BYTES   (MAX_BYTES)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .clock_level_i   (clock_level_i),
    .data_level_i    (data_level_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .character_i     (character_o),
    .measurement_ok_i(measurement_ok_o),
    .last_i          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // One window in four is left free of idle cycles on both sides.
  assign calm = (cycle_count[9:8] == 2'd0);

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Report sink: random short stalls, a few long ones, and a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_asks != hold_taken) begin
      hold_taken  <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Valid stays high from one transaction to the next; it only drops for a gap
  // or when some other activity takes over the process.
  task automatic send_tick(input logic lvl, input logic data);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    clock_level_i <= lvl;
    data_level_i  <= data;
    do @(posedge clk_i); while (in_stall_o);
    ticks_sent++;
  endtask

  task automatic send_bit(input logic value, input int unsigned low_len,
                          input int unsigned high_len, input int unsigned flip_pct);
    for (int unsigned k = 0; k < low_len; k++) begin
      send_tick(1'b0, value ^ ($urandom_range(0, 99) < flip_pct));
    end
    for (int unsigned k = 0; k < high_len; k++) begin
      send_tick(1'b1, 1'($urandom_range(0, 1)));
    end
  endtask

  // High stretches inside the frame stay within the cutoff; the last one runs
  // past it so that the frame closes.
  task automatic send_frame(input logic [143:0] pattern, input int unsigned nbits,
                            input int unsigned low_max, input int unsigned flip_pct);
    int unsigned cut;
    int unsigned high_len;
    cut = (cur_cutoff == 0) ? 1 : cur_cutoff;
    for (int unsigned i = 0; i < nbits; i++) begin
      if (i == nbits - 1) high_len = cut + 1 + $urandom_range(0, 2);
      else high_len = $urandom_range(1, (cut < 4) ? cut : 4);
      send_bit(pattern[i], $urandom_range(1, low_max), high_len, flip_pct);
    end
  endtask

  function automatic logic [143:0] random_pattern();
    logic [143:0] bits;
    for (int i = 0; i < 144; i++) bits[i] = 1'($urandom_range(0, 1));
    return bits;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] interval, input logic [CFG_W-1:0] cutoff);
    drain();
    cfg_valid_i <= 1'b1;
    for (int r = 0; r < 2; r++) begin
      cfg_index_i <= (r == 0) ? CFG_SAMPLE_INTERVAL : CFG_CUTOFF_TICKS;
      cfg_data_i  <= (r == 0) ? interval : cutoff;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cur_cutoff = cutoff;
  endtask

  // Mostly clean 24-bit frames with noisy data, plus odd lengths and line noise.
  task automatic random_frame();
    int unsigned kind;
    int unsigned n;
    int unsigned cut;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      send_frame(random_pattern(), FRAME_LENGTH * 8, $urandom_range(1, 3),
                 $urandom_range(0, 30));
    end else if (kind == 7) begin
      send_frame(random_pattern(), FRAME_LENGTH * 8 - 2 + $urandom_range(0, 4),
                 $urandom_range(1, 3), $urandom_range(0, 20));
    end else if (kind == 8) begin
      send_frame(random_pattern(), $urandom_range(1, 40), $urandom_range(1, 2),
                 $urandom_range(0, 20));
    end else begin
      n = $urandom_range(5, 30);
      for (int unsigned k = 0; k < n; k++) begin
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      cut = (cur_cutoff == 0) ? 1 : cur_cutoff;
      for (int unsigned k = 0; k <= cut; k++) send_tick(1'b1, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned start_ticks;
    int unsigned frames;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_timing(16'd1, 16'd2);
    // Nibbles at both extremes, a partial byte after three bytes and a lone bit.
    send_frame({8'h5A, 8'hFF, 8'h00}, 24, 1, 0);
    send_frame({144{1'b1}}, 25, 1, 0);
    send_frame(144'h1, 1, 1, 0);

    // Zero in both registers behaves like one.
    set_timing(16'd0, 16'd0);
    send_frame({8'h12, 8'h34, 8'h56}, 24, 2, 20);

    // Widest interval: only the sample taken at the falling edge counts.
    set_timing(16'hFFFF, 16'd3);
    send_frame(random_pattern(), 8, 3, 30);

    // The sink holds off while short frames keep arriving, so the report queue
    // fills and the tick input stalls; then everything is allowed to drain.
    set_timing(16'd1, 16'd1);
    hold_asks++;
    for (int unsigned k = 0; k < 6; k++) send_frame(random_pattern(), $urandom_range(1, 2), 1, 0);
    drain();

    set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 8)));
    start_ticks = ticks_sent;
    frames = 0;
    while (ticks_sent - start_ticks < 40 || frames < 1) begin
      random_frame();
      frames++;
    end

    drain();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/dgsfd_pkg.sv
src/dgsfd_front.sv
src/dgsfd_queue.sv
src/dgsfd_back.sv
src/dial_gauge_serial_frame_decoder_core.sv
tb/frame_decoder_checker.sv
tb/testbench.sv
